// ----- design/assert_macros.svh -----
// assertion macros for the hash table engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold in the same cycle as its trigger
`define HTE_ASSERT_IMP(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);
// property that must hold in the cycle after its trigger
`define HTE_ASSERT_NXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define HTE_ASSERT_IMP(lbl, clk, rstn, cond, prop, msg)
`define HTE_ASSERT_NXT(lbl, clk, rstn, cond, prop, msg)
`endif
`endif

// ----- design/hte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg
// types, sizes and hash functions shared by the hash table engine
// ----------------------------------------------------------------------------
package hte_pkg;
    localparam int BUCKETS    = 256;
    localparam int POOL_NODES = 256;
    localparam int VALUE_BITS = 32;
    localparam int HASH_W     = 32;
    localparam int IDX_W      = $clog2(BUCKETS);
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int LINK_W     = $clog2(POOL_NODES + 1);
    localparam int BCNT_W     = 9;
    localparam int CNT_W      = 10;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  key_byte;
        logic        last;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [31:0]      result_value;
        logic             pool_overflow;
        logic [CNT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [HASH_W-1:0]     hash;
        logic [VALUE_BITS-1:0] value;
        logic [LINK_W-1:0]     next;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE, S_MIX, S_DIV_START, S_DIV, S_HRD, S_HCHK, S_NRD, S_NCHK, S_NWR, S_RESP
    } t_state;

    function automatic logic [HASH_W-1:0] hash_byte(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
        logic [HASH_W-1:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [HASH_W-1:0] hash_final(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction
endpackage

// ----- design/hte_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/hte_divmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_divmod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module hte_divmod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hte_pkg::HASH_W-1:0]   i_dividend,
    input  logic [hte_pkg::BCNT_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [hte_pkg::BCNT_W-1:0]   o_rem
);
    import hte_pkg::*;

    localparam int CW = $clog2(HASH_W);

    logic              r_busy, r_done;
    logic [CW-1:0]     r_cnt;
    logic [HASH_W-1:0] r_q;
    logic [BCNT_W-1:0] r_rem, r_d;
    logic [BCNT_W:0]   trial;
    logic [BCNT_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_q[HASH_W-1]};
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[HASH_W-2:0], 1'b0};
            // remainder stays below the divisor, so it fits back in BCNT_W bits
            if (trial >= {1'b0, r_d}) begin
                r_rem <= diff[BCNT_W-1:0];
            end else begin
                r_rem <= trial[BCNT_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ----- design/chained_hash_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// hash table with chained overflow nodes, keyed by a one-at-a-time hash
// ----------------------------------------------------------------------------
// key bytes enter on the input channel, one item per cycle while idle.
// a byte without last gives no result and only updates the running hash. the byte
// marked last carries op and value; it gives one result item on the output channel.
// after a last byte the block runs the final mix, a bit-serial remainder by
// bucket_count, a head read and check, then a read and check per chain node
// walked, a node write to append on a put to a non-empty chain, and a load
// of the output register. the head and node tables sit in registered-read
// rams; the chain walk through the node ram makes the run time vary with
// chain length.
// the result sits in an output register; if the receiver stalls, the block
// finishes the next key's bytes and holds in its response state until the
// register is free.
// reset clears all head valid bits, the pool and entry counters and sets
// bucket_count to 256; ram contents need no clearing.
// the apb port holds bucket_count at address 0, pready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chained_hash_table_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hte_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hte_pkg::t_out                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hte_pkg::ADDR_W-1:0]    paddr,
    input  logic [hte_pkg::DATA_W-1:0]    pwdata,
    output logic [hte_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import hte_pkg::*;

    t_state                r_state, n_state;
    logic [BCNT_W-1:0]     r_bcount;
    logic [HASH_W-1:0]     r_hash, n_hash;
    logic [HASH_W-1:0]     r_h, n_h;
    logic                  r_op, n_op;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [LINK_W-1:0]     r_link, n_link;
    logic [LINK_W-1:0]     r_nodes, n_nodes;
    logic [CNT_W-1:0]      r_entries, n_entries;
    logic                  r_found, n_found;
    logic                  r_ovf, n_ovf;
    logic [31:0]           r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;
    logic [BUCKETS-1:0]    r_head_valid;

    logic [BCNT_W-1:0]     eff_buckets;
    logic                  div_start, div_busy, div_done;
    logic [BCNT_W-1:0]     div_rem;
    logic                  head_set;
    logic                  hd_we, hd_re, nd_we, nd_re;
    t_entry                hd_wdata, nd_wdata, hd_rdata, nd_rdata;
    logic [NODE_W-1:0]     nd_waddr, nd_raddr;
    logic [NODE_W-1:0]     link_addr;
    logic [LINK_W-1:0]     new_link;
    t_entry                new_entry;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= BCNT_W'(BUCKETS);
        end else if (psel && penable && pwrite && paddr[2] == REG_BUCKET_COUNT) begin
            r_bcount <= pwdata[BCNT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? {{(DATA_W-BCNT_W){1'b0}}, r_bcount} : '0;

    always_comb begin
        if (r_bcount == '0) begin
            eff_buckets = BCNT_W'(1);
        end else if (r_bcount > BCNT_W'(BUCKETS)) begin
            eff_buckets = BCNT_W'(BUCKETS);
        end else begin
            eff_buckets = r_bcount;
        end
    end

    hte_divmod u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_h),
        .i_divisor  (eff_buckets),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    hte_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (r_idx),
        .i_wdata (hd_wdata),
        .i_re    (hd_re),
        .i_raddr (r_idx),
        .o_rdata (hd_rdata)
    );

    hte_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_re    (nd_re),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign link_addr = NODE_W'(r_link - 1'b1);
    assign new_link  = r_nodes + 1'b1;
    assign new_entry = '{hash: r_h, value: r_val, next: '0};

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_h         = r_h;
        n_op        = r_op;
        n_val       = r_val;
        n_idx       = r_idx;
        n_link      = r_link;
        n_nodes     = r_nodes;
        n_entries   = r_entries;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        div_start   = 1'b0;
        head_set    = 1'b0;
        hd_we       = 1'b0;
        hd_re       = 1'b0;
        hd_wdata    = new_entry;
        nd_we       = 1'b0;
        nd_re       = 1'b0;
        nd_waddr    = r_nodes[NODE_W-1:0];
        nd_wdata    = new_entry;
        nd_raddr    = link_addr;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.last) begin
                        n_hash  = '0;
                        n_h     = hash_byte(r_hash, i_in_data.key_byte);
                        n_op    = i_in_data.op;
                        n_val   = i_in_data.value[VALUE_BITS-1:0];
                        n_state = S_MIX;
                    end else begin
                        n_hash = hash_byte(r_hash, i_in_data.key_byte);
                    end
                end
            end
            S_MIX: begin
                n_h     = hash_final(r_h);
                n_found = 1'b0;
                n_ovf   = 1'b0;
                n_res   = '0;
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_idx   = div_rem[IDX_W-1:0];
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                hd_re   = 1'b1;
                n_state = S_HCHK;
            end
            S_HCHK: begin
                n_state = S_RESP;
                if (r_op == OP_PUT) begin
                    if (!r_head_valid[r_idx]) begin
                        hd_we     = 1'b1;
                        head_set  = 1'b1;
                        n_entries = r_entries + 1'b1;
                        n_found   = 1'b1;
                    end else if (r_nodes == LINK_W'(POOL_NODES)) begin
                        n_ovf = 1'b1;
                    end else if (hd_rdata.next == '0) begin
                        // empty chain: new node and head link written in the same cycle
                        nd_we     = 1'b1;
                        hd_we     = 1'b1;
                        hd_wdata  = '{hash: hd_rdata.hash, value: hd_rdata.value,
                                      next: new_link};
                        n_nodes   = new_link;
                        n_entries = r_entries + 1'b1;
                        n_found   = 1'b1;
                    end else begin
                        n_link  = hd_rdata.next;
                        n_state = S_NRD;
                    end
                end else if (r_head_valid[r_idx]) begin
                    if (hd_rdata.hash == r_h) begin
                        n_found = 1'b1;
                        n_res   = 32'(hd_rdata.value);
                    end else if (hd_rdata.next != '0) begin
                        n_link  = hd_rdata.next;
                        n_state = S_NRD;
                    end
                end
            end
            S_NRD: begin
                nd_re   = 1'b1;
                n_state = S_NCHK;
            end
            S_NCHK: begin
                if (r_op == OP_PUT) begin
                    if (nd_rdata.next == '0) begin
                        // tail found: relink it, node written next cycle
                        nd_we    = 1'b1;
                        nd_waddr = link_addr;
                        nd_wdata = '{hash: nd_rdata.hash, value: nd_rdata.value,
                                     next: new_link};
                        n_state  = S_NWR;
                    end else begin
                        n_link  = nd_rdata.next;
                        n_state = S_NRD;
                    end
                end else if (nd_rdata.hash == r_h) begin
                    n_found = 1'b1;
                    n_res   = 32'(nd_rdata.value);
                    n_state = S_RESP;
                end else if (nd_rdata.next == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_link  = nd_rdata.next;
                    n_state = S_NRD;
                end
            end
            S_NWR: begin
                nd_we     = 1'b1;
                n_nodes   = new_link;
                n_entries = r_entries + 1'b1;
                n_found   = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{found: r_found, result_value: r_res,
                                    pool_overflow: r_ovf, entry_count: r_entries};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hash       <= '0;
            r_nodes      <= '0;
            r_entries    <= '0;
            r_out_valid  <= 1'b0;
            r_head_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_nodes     <= n_nodes;
            r_entries   <= n_entries;
            r_out_valid <= n_out_valid;
            if (head_set) begin
                r_head_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h     <= n_h;
        r_op    <= n_op;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_link  <= n_link;
        r_found <= n_found;
        r_ovf   <= n_ovf;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    `HTE_ASSERT_IMP(a_pool_bound, i_clk, i_rst_n, 1'b1, r_nodes <= LINK_W'(POOL_NODES), "pool count beyond pool size")
    `HTE_ASSERT_IMP(a_ovf_not_found, i_clk, i_rst_n, o_out_valid && o_out_data.pool_overflow, !o_out_data.found, "overflow item reports found")
    `HTE_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, div_busy, r_state == S_DIV, "remainder unit busy outside its state")
    `HTE_ASSERT_NXT(a_head_set_valid, i_clk, i_rst_n, head_set, r_head_valid[$past(r_idx)], "head fill did not set valid bit")
endmodule

// ----- test/chained_hash_table_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_tb
// random and directed key streams checked against a behavioral hash table
// ----------------------------------------------------------------------------
// keys are streamed as byte items with put or get. every last byte is run
// through a local one-at-a-time hash and a chained table model, and the
// predicted result item is queued and compared field by field with the block.
// bucket_count is rewritten over the apb port between phases while idle.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_tb;
    import hte_pkg::*;

    localparam int STALL_LIMIT  = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    chained_hash_table_engine u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // table model
    logic [8:0]  tbl_buckets;
    logic [31:0] key_hash;
    logic        bkt_used [BUCKETS];
    logic [31:0] bkt_hash [BUCKETS];
    logic [31:0] bkt_val  [BUCKETS];
    int          bkt_link [BUCKETS];
    logic [31:0] pool_hash [POOL_NODES];
    logic [31:0] pool_val  [POOL_NODES];
    int          pool_link [POOL_NODES];
    int          pool_fill;
    int          entries;

    t_in  key_items [$];
    t_out want_results [$];
    int   errors = 0;
    int   results_seen = 0;
    int   idle_pct = 6;
    bit   hold_receiver = 0;
    bit   run_done = 0;
    int   quiet_cycles = 0;
    int   gets_hit = 0, overflows = 0;

    function automatic logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
        h = h + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    task automatic table_clear();
        for (int i = 0; i < BUCKETS; i++) begin
            bkt_used[i] = 0;
            bkt_link[i] = 0;
        end
        pool_fill = 0;
        entries = 0;
        key_hash = '0;
        tbl_buckets = 9'd256;
    endtask

    task automatic predict_item(t_in it);
        logic [31:0] h;
        int   nb, idx, lk;
        t_out r;
        h = fold_byte(key_hash, it.key_byte);
        if (!it.last) begin
            key_hash = h;
            return;
        end
        key_hash = '0;
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        nb = (tbl_buckets == 0) ? 1 : (tbl_buckets > BUCKETS ? BUCKETS : tbl_buckets);
        idx = h % nb;
        r = '0;
        if (it.op == OP_PUT) begin
            if (!bkt_used[idx]) begin
                bkt_used[idx] = 1;
                bkt_hash[idx] = h;
                bkt_val[idx] = it.value;
                bkt_link[idx] = 0;
                entries++;
                r.found = 1;
            end else if (pool_fill < POOL_NODES) begin
                pool_hash[pool_fill] = h;
                pool_val[pool_fill] = it.value;
                pool_link[pool_fill] = 0;
                if (bkt_link[idx] == 0) bkt_link[idx] = pool_fill + 1;
                else begin
                    lk = bkt_link[idx];
                    while (pool_link[lk-1] != 0) lk = pool_link[lk-1];
                    pool_link[lk-1] = pool_fill + 1;
                end
                pool_fill++;
                entries++;
                r.found = 1;
            end else begin
                r.pool_overflow = 1;
                overflows++;
            end
        end else if (bkt_used[idx]) begin
            if (bkt_hash[idx] == h) begin
                r.found = 1;
                r.result_value = bkt_val[idx];
            end else begin
                lk = bkt_link[idx];
                while (lk != 0) begin
                    if (pool_hash[lk-1] == h) begin
                        r.found = 1;
                        r.result_value = pool_val[lk-1];
                        break;
                    end
                    lk = pool_link[lk-1];
                end
            end
            if (r.found) gets_hit++;
        end
        r.entry_count = (entries > 1023) ? 10'd1023 : entries[9:0];
        want_results.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) predict_item(i_in_data);
            if (key_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= key_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (want_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, o_out_data);
                    errors++;
                end else begin
                    exp_r = want_results.pop_front();
                    if (o_out_data.found !== exp_r.found) begin
                        $display("%0t: found exp %0d got %0d", $time, exp_r.found,
                                 o_out_data.found);
                        errors++;
                    end
                    if (o_out_data.result_value !== exp_r.result_value) begin
                        $display("%0t: value exp %h got %h", $time, exp_r.result_value,
                                 o_out_data.result_value);
                        errors++;
                    end
                    if (o_out_data.pool_overflow !== exp_r.pool_overflow) begin
                        $display("%0t: overflow exp %0d got %0d", $time,
                                 exp_r.pool_overflow, o_out_data.pool_overflow);
                        errors++;
                    end
                    if (o_out_data.entry_count !== exp_r.entry_count) begin
                        $display("%0t: entry_count exp %0d got %0d", $time,
                                 exp_r.entry_count, o_out_data.entry_count);
                        errors++;
                    end
                end
            end
            i_out_ready <= !hold_receiver && ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !run_done) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("** chained_hash_table_engine: FAILED **");
            $finish;
        end
    end

    task automatic add_key(logic op, int nbytes, logic [31:0] val, logic [7:0] seed);
        t_in it;
        for (int i = 0; i < nbytes; i++) begin
            it.op = logic'($urandom_range(1));
            it.key_byte = (seed == 0) ? 8'($urandom) : seed + 8'(i);
            it.last = (i == nbytes - 1);
            it.value = $urandom;
            if (it.last) begin
                it.op = op;
                it.value = val;
            end
            key_items.push_back(it);
        end
    endtask

    task automatic wait_drain();
        while (key_items.size() > 0 || i_in_valid || want_results.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [8:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(4 * REG_BUCKET_COUNT); pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tbl_buckets = v;
    endtask

    // random phase: puts and gets mixed on a remembered key set, plus random keys with random ops
    task automatic random_phase(int nkeys);
        logic [7:0] seeds [$];
        for (int k = 0; k < nkeys; k++) begin
            if ($urandom_range(99) < 45 || seeds.size() == 0) begin
                seeds.push_back(8'($urandom_range(1, 255)));
                add_key(OP_PUT, $urandom_range(1, 3), $urandom, seeds[$]);
            end else if ($urandom_range(99) < 85) begin
                add_key(OP_GET, $urandom_range(1, 3), 0,
                        seeds[$urandom_range(seeds.size() - 1)]);
            end else begin
                add_key(logic'($urandom_range(1)), $urandom_range(1, 4), $urandom, 8'd0);
            end
        end
    endtask

    initial begin
        int seen_before;
        table_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both ops, duplicates, single and multi byte keys
        add_key(OP_PUT, 1, 32'hFFFF_FFFF, 8'hFF);
        add_key(OP_PUT, 1, 32'h0, 8'h00 + 8'd1);
        add_key(OP_GET, 1, 0, 8'hFF);
        add_key(OP_PUT, 1, 32'h1234_5678, 8'hFF);
        add_key(OP_GET, 1, 0, 8'hFF);
        add_key(OP_GET, 2, 0, 8'h80);
        add_key(OP_PUT, 4, 32'hA5A5_5A5A, 8'h7F);
        add_key(OP_GET, 4, 0, 8'h7F);
        wait_drain();

        // one bucket: long chains and then pool exhaustion
        apb_write(9'd1);
        random_phase(60);
        wait_drain();
        apb_write(9'd0);
        for (int i = 0; i < 230; i++) add_key(OP_PUT, 1, $urandom, 8'($urandom_range(1, 255)));
        add_key(OP_GET, 1, 0, 8'h33);
        // receiver holds off while the sender keeps going
        hold_receiver = 1;
        repeat (400) @(posedge i_clk);
        hold_receiver = 0;
        wait_drain();

        // table contents carry over; remaining settings with random traffic
        apb_write(9'd511);
        idle_pct = 0;
        random_phase(120);
        wait_drain();
        idle_pct = 6;
        apb_write(9'd256);
        random_phase(200);
        wait_drain();
        apb_write(9'd7);
        random_phase(250);
        wait_drain();
        apb_write(9'(($urandom_range(2, 255))));
        random_phase(250);
        wait_drain();

        run_done = 1;
        repeat (200) @(posedge i_clk);
        seen_before = results_seen;
        $display("covered %0d results, %0d get hits, %0d pool overflows",
                 seen_before, gets_hit, overflows);
        $display("bucket counts 0, 1, 7, 256, 511 and a random one were exercised");
        if (errors == 0 && want_results.size() == 0)
            $display("** chained_hash_table_engine: PASSED **");
        else
            $display("** chained_hash_table_engine: FAILED **");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/hte_pkg.sv
design/hte_ram.sv
design/hte_divmod.sv
design/chained_hash_table_engine.sv
test/chained_hash_table_engine_tb.sv
